// ===== rtl/core/cbm_pkg.sv =====
`default_nettype none

package cbm_pkg;

    // Item kinds
    typedef enum logic
    {
        OP_CPU_WRITE = 1'b0,
        OP_TICK      = 1'b1
    } opcode_t;

    // CPU address pages (address bits 15:12)
    localparam logic [3:0] PAGE_PRG_LO    = 4'h8;
    localparam logic [3:0] PAGE_PRG_HI    = 4'hA;
    localparam logic [3:0] PAGE_CHR_FIRST = 4'hB;
    localparam logic [3:0] PAGE_CHR_LAST  = 4'hE;
    localparam logic [3:0] PAGE_IRQ       = 4'hF;

    // IRQ register select (address bits 3:2) within the IRQ page
    localparam logic [1:0] IRQ_SEL_RELOAD_LO = 2'd0;
    localparam logic [1:0] IRQ_SEL_RELOAD_HI = 2'd1;
    localparam logic [1:0] IRQ_SEL_CONTROL   = 2'd2;
    localparam logic [1:0] IRQ_SEL_ACK       = 2'd3;

    localparam int          NUM_CHR_BANKS = 8;
    localparam logic [7:0]  IRQ_COUNT_MAX = 8'hFF;
    localparam logic [1:0]  IRQ_EN_COUNT  = 2'b10;
    localparam logic [1:0]  IRQ_EN_AUTO   = 2'b01;

    typedef struct packed
    {
        logic        opcode;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed
    {
        logic [7:0] prg_bank_lo;
        logic [7:0] prg_bank_hi;
        logic [7:0] chr_bank_0;
        logic [7:0] chr_bank_1;
        logic [7:0] chr_bank_2;
        logic [7:0] chr_bank_3;
        logic [7:0] chr_bank_4;
        logic [7:0] chr_bank_5;
        logic [7:0] chr_bank_6;
        logic [7:0] chr_bank_7;
        logic       irq_line;
    } result_t;

    // Enable bits after an IRQ fires or is acknowledged
    function automatic logic [1:0] auto_reload_enable(input logic [1:0] en);
        return en[0] ? (IRQ_EN_COUNT | IRQ_EN_AUTO) : 2'b00;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper_irq_unit.sv =====
`default_nettype none

// Cartridge bank mapper with scanline IRQ counter.
// Input channel (item_valid / item_stall / item): one beat is either a CPU
// write (cpu_address, write_data) or a scanline tick (opcode set).
// Output channel (result_valid / result_stall / result): one beat per input
// beat, in order, carrying both program banks, all eight character banks
// and the IRQ line as they stand after that input.
// Path: an accepted beat is held in the input register, then passes the
// decode/update logic into the result register.
// Throughput: one beat per cycle; the input register takes a new beat in
// every cycle in which the result register is empty or being drained.
// When the receiver holds result_stall, the result register keeps its beat,
// the input register fills, and item_stall rises only once both are full.
// Reset (rst_n low, asynchronous) empties both registers and loads program
// banks 0 and 1, character bank i with i, and clears the IRQ counter,
// reload value, enable bits and pending flag.
module cartridge_bank_mapper_irq_unit
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  cbm_pkg::item_t        item,
    output logic                  result_valid,
    input  wire                   result_stall,
    output cbm_pkg::result_t      result
);
    import cbm_pkg::*;

    // Pipeline registers
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    out_next;

    // Mapper state
    logic [7:0] prg_reg [2];
    logic [7:0] prg_next [2];
    logic [7:0] chr_reg [NUM_CHR_BANKS];
    logic [7:0] chr_next [NUM_CHR_BANKS];
    logic [1:0] irq_en_reg;
    logic [1:0] irq_en_next;
    logic [7:0] irq_count_reg;
    logic [7:0] irq_count_next;
    logic [7:0] irq_reload_reg;
    logic [7:0] irq_reload_next;
    logic       irq_pending_reg;
    logic       irq_pending_next;

    logic       advance;
    logic       item_take;
    logic [3:0] page;
    logic [1:0] sel;
    logic [3:0] nib;
    logic [3:0] chr_page_ofs;
    logic [2:0] chr_idx;

    // Handshake: input register drains into result register when it is free
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = in_valid_reg && !advance;
    assign item_take    = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Address decode
    assign page         = in_item_reg.cpu_address[15:12];
    assign sel          = in_item_reg.cpu_address[3:2];
    assign nib          = in_item_reg.write_data[3:0];
    assign chr_page_ofs = page - PAGE_CHR_FIRST;
    assign chr_idx      = {chr_page_ofs[1:0], sel[1]};

    // Next state for the beat in the input register
    always_comb
    begin
        prg_next         = prg_reg;
        chr_next         = chr_reg;
        irq_en_next      = irq_en_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_pending_next = irq_pending_reg;

        if (in_item_reg.opcode == OP_TICK)
        begin
            if ((irq_en_reg & IRQ_EN_COUNT) != 2'b00)
            begin
                if (irq_count_reg == IRQ_COUNT_MAX)
                begin
                    irq_pending_next = 1'b1;
                    irq_count_next   = irq_reload_reg;
                    irq_en_next      = auto_reload_enable(irq_en_reg);
                end
                else
                begin
                    irq_count_next = irq_count_reg + 8'd1;
                end
            end
        end
        else if (page == PAGE_PRG_LO)
        begin
            prg_next[0] = in_item_reg.write_data;
        end
        else if (page == PAGE_PRG_HI)
        begin
            prg_next[1] = in_item_reg.write_data;
        end
        else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST)
        begin
            if (sel[0])
            begin
                chr_next[chr_idx] = {nib, chr_reg[chr_idx][3:0]};
            end
            else
            begin
                chr_next[chr_idx] = {chr_reg[chr_idx][7:4], nib};
            end
        end
        else if (page == PAGE_IRQ)
        begin
            case (sel)
                IRQ_SEL_RELOAD_LO:
                begin
                    irq_reload_next = {irq_reload_reg[7:4], nib};
                end
                IRQ_SEL_RELOAD_HI:
                begin
                    irq_reload_next = {nib, irq_reload_reg[3:0]};
                end
                IRQ_SEL_CONTROL:
                begin
                    irq_en_next = in_item_reg.write_data[1:0];
                    if ((in_item_reg.write_data[1:0] & IRQ_EN_COUNT) != 2'b00)
                    begin
                        irq_count_next = irq_reload_reg;
                    end
                end
                IRQ_SEL_ACK:
                begin
                    irq_en_next = auto_reload_enable(irq_en_reg);
                end
                default:
                begin
                    irq_en_next = irq_en_reg;
                end
            endcase
            irq_pending_next = 1'b0;
        end
    end

    // Result snapshot of the updated state
    always_comb
    begin
        out_next.prg_bank_lo = prg_next[0];
        out_next.prg_bank_hi = prg_next[1];
        out_next.chr_bank_0  = chr_next[0];
        out_next.chr_bank_1  = chr_next[1];
        out_next.chr_bank_2  = chr_next[2];
        out_next.chr_bank_3  = chr_next[3];
        out_next.chr_bank_4  = chr_next[4];
        out_next.chr_bank_5  = chr_next[5];
        out_next.chr_bank_6  = chr_next[6];
        out_next.chr_bank_7  = chr_next[7];
        out_next.irq_line    = irq_pending_next;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Mapper state registers, updated as each beat leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg[0]      <= 8'd0;
            prg_reg[1]      <= 8'd1;
            for (int i = 0; i < NUM_CHR_BANKS; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
            irq_en_reg      <= 2'b00;
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 8'd0;
            irq_pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            prg_reg         <= prg_next;
            chr_reg         <= chr_next;
            irq_en_reg      <= irq_en_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_pending_reg <= irq_pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/cartridge_bank_mapper_irq_unit_tb.sv =====
`timescale 1ns / 100ps

module cartridge_bank_mapper_irq_unit_tb;

    import cbm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 290;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    result_stall = 1'b0;
    item_t   item         = '0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    // Stimulus and expected bank views
    item_t   bus_events[$];
    result_t bank_views_due[$];
    int      events_queued = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      mismatches = 0;
    int      cycles = 0;

    // Mapper state as the predictor sees it
    logic [7:0] prg_pred [2];
    logic [7:0] chr_pred [NUM_CHR_BANKS];
    logic [1:0] irq_en_pred;
    logic [7:0] irq_count_pred;
    logic [7:0] irq_reload_pred;
    logic       irq_pend_pred;

    cartridge_bank_mapper_irq_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Enable bits after a fire or an acknowledge: keep counting only with auto-reload
    function automatic logic [1:0] enable_after_fire(input logic [1:0] en);
        return ((en & IRQ_EN_AUTO) != 2'b00) ? (IRQ_EN_COUNT | IRQ_EN_AUTO) : 2'b00;
    endfunction

    // Apply one write or tick to the predicted state; return the bank view after it
    function automatic result_t apply_bus_event(input item_t ev);
        logic [3:0] page;
        logic [1:0] sel;
        logic [3:0] nib;
        int         k;
        result_t    view;
        page = ev.cpu_address[15:12];
        sel  = ev.cpu_address[3:2];
        nib  = ev.write_data[3:0];
        if (ev.opcode == OP_TICK)
        begin
            if ((irq_en_pred & IRQ_EN_COUNT) != 2'b00)
            begin
                if (irq_count_pred == IRQ_COUNT_MAX)
                begin
                    irq_pend_pred  = 1'b1;
                    irq_count_pred = irq_reload_pred;
                    irq_en_pred    = enable_after_fire(irq_en_pred);
                end
                else
                begin
                    irq_count_pred = irq_count_pred + 8'd1;
                end
            end
        end
        else if (page == PAGE_PRG_LO)
        begin
            prg_pred[0] = ev.write_data;
        end
        else if (page == PAGE_PRG_HI)
        begin
            prg_pred[1] = ev.write_data;
        end
        else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST)
        begin
            k = 2 * int'(page - PAGE_CHR_FIRST) + int'(sel[1]);
            if (sel[0])
                chr_pred[k][7:4] = nib;
            else
                chr_pred[k][3:0] = nib;
        end
        else if (page == PAGE_IRQ)
        begin
            case (sel)
                IRQ_SEL_RELOAD_LO: irq_reload_pred[3:0] = nib;
                IRQ_SEL_RELOAD_HI: irq_reload_pred[7:4] = nib;
                IRQ_SEL_CONTROL:
                begin
                    irq_en_pred = ev.write_data[1:0];
                    if ((irq_en_pred & IRQ_EN_COUNT) != 2'b00)
                        irq_count_pred = irq_reload_pred;
                end
                default:           irq_en_pred = enable_after_fire(irq_en_pred);
            endcase
            irq_pend_pred = 1'b0;
        end
        view.prg_bank_lo = prg_pred[0];
        view.prg_bank_hi = prg_pred[1];
        view.chr_bank_0  = chr_pred[0];
        view.chr_bank_1  = chr_pred[1];
        view.chr_bank_2  = chr_pred[2];
        view.chr_bank_3  = chr_pred[3];
        view.chr_bank_4  = chr_pred[4];
        view.chr_bank_5  = chr_pred[5];
        view.chr_bank_6  = chr_pred[6];
        view.chr_bank_7  = chr_pred[7];
        view.irq_line    = irq_pend_pred;
        return view;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %02h got %02h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
            note_mismatch(what, want, got);
    endtask

    // IRQ page address with the register select in bits 3:2 and junk elsewhere
    function automatic logic [15:0] irq_addr(input logic [1:0] sel);
        return {PAGE_IRQ, 8'($urandom), sel, 2'($urandom)};
    endfunction

    task automatic queue_write(input logic [15:0] addr, input logic [7:0] data);
        item_t ev;
        ev.opcode      = OP_CPU_WRITE;
        ev.cpu_address = addr;
        ev.write_data  = data;
        bus_events.push_back(ev);
        events_queued++;
    endtask

    // Ticks carry random address and data, which must be ignored
    task automatic queue_tick();
        item_t ev;
        ev.opcode      = OP_TICK;
        ev.cpu_address = 16'($urandom);
        ev.write_data  = 8'($urandom);
        bus_events.push_back(ev);
        events_queued++;
    endtask

    // IRQ programming followed by tick runs, mixed with lone ticks and other writes
    task automatic queue_random_traffic(input int count);
        int target;
        int pick;
        target = events_queued + count;
        while (events_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                queue_write(irq_addr(IRQ_SEL_RELOAD_LO), 8'($urandom));
                queue_write(irq_addr(IRQ_SEL_RELOAD_HI),
                            {4'($urandom), ($urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom)});
                queue_write(irq_addr(IRQ_SEL_CONTROL),
                            {6'($urandom), ($urandom_range(0, 4) != 0), 1'($urandom)});
                repeat ($urandom_range(2, 24)) queue_tick();
                if ($urandom_range(0, 1) != 0)
                    queue_write(irq_addr(IRQ_SEL_ACK), 8'($urandom));
            end
            else if (pick < 50)
                queue_tick();
            else if (pick < 58)
                queue_write({1'b0, 15'($urandom)}, 8'($urandom));
            else if (pick < 62)
                queue_write({4'h9, 12'($urandom)}, 8'($urandom));
            else if (pick < 72)
                queue_write({($urandom_range(0, 1) != 0) ? PAGE_PRG_HI : PAGE_PRG_LO,
                             12'($urandom)}, 8'($urandom));
            else if (pick < 90)
                queue_write({4'($urandom_range(PAGE_CHR_FIRST, PAGE_CHR_LAST)), 12'($urandom)},
                            8'($urandom));
            else
                queue_write({PAGE_IRQ, 12'($urandom)}, 8'($urandom));
        end
    endtask

    // Wait until every queued beat is accepted and every bank view has come back
    task automatic wait_all_drained();
        while (bus_events.size() != 0 || item_valid || bank_views_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        wait_all_drained();
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_traffic(PHASE_ITEMS);
    endtask

    // Driver: present the next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                bank_views_due.push_back(apply_bus_event(item));
            if (!item_valid || !item_stall)
            begin
                if (bus_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item       <= bus_events.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: each result beat against the oldest predicted bank view
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (bank_views_due.size() == 0)
            begin
                note_mismatch("beat with none due, irq_line", 8'h00, {7'd0, result.irq_line});
            end
            else
            begin
                want = bank_views_due.pop_front();
                check_field("prg_bank_lo", want.prg_bank_lo, result.prg_bank_lo);
                check_field("prg_bank_hi", want.prg_bank_hi, result.prg_bank_hi);
                check_field("chr_bank_0", want.chr_bank_0, result.chr_bank_0);
                check_field("chr_bank_1", want.chr_bank_1, result.chr_bank_1);
                check_field("chr_bank_2", want.chr_bank_2, result.chr_bank_2);
                check_field("chr_bank_3", want.chr_bank_3, result.chr_bank_3);
                check_field("chr_bank_4", want.chr_bank_4, result.chr_bank_4);
                check_field("chr_bank_5", want.chr_bank_5, result.chr_bank_5);
                check_field("chr_bank_6", want.chr_bank_6, result.chr_bank_6);
                check_field("chr_bank_7", want.chr_bank_7, result.chr_bank_7);
                check_field("irq_line", {7'd0, want.irq_line}, {7'd0, result.irq_line});
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        // Predicted state after reset
        prg_pred[0] = 8'd0;
        prg_pred[1] = 8'd1;
        for (int i = 0; i < NUM_CHR_BANKS; i++)
            chr_pred[i] = 8'(i);
        irq_en_pred     = 2'b00;
        irq_count_pred  = 8'd0;
        irq_reload_pred = 8'd0;
        irq_pend_pred   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: program bank extremes, ignored regions, nibble writes, IRQ fire paths
        queue_write({PAGE_PRG_LO, 12'h000}, 8'hFF);
        queue_write({PAGE_PRG_HI, 12'hFFF}, 8'h00);
        queue_write(16'h0000, 8'hAA);
        queue_write(16'h7FFF, 8'h55);
        queue_write(16'h9000, 8'h12);
        queue_write(16'h9FFF, 8'hFF);
        queue_write({PAGE_CHR_FIRST, 12'h000}, 8'hFF);
        queue_write({PAGE_CHR_FIRST, 12'h00C}, 8'hA5);
        queue_write({4'hC, 12'h004}, 8'h3C);
        queue_write({4'hD, 12'h008}, 8'h0F);
        queue_write({PAGE_CHR_LAST, 12'hFFF}, 8'hF0);
        queue_write(irq_addr(IRQ_SEL_RELOAD_LO), 8'hFE);
        queue_write(irq_addr(IRQ_SEL_RELOAD_HI), 8'hFF);
        queue_write(irq_addr(IRQ_SEL_CONTROL), 8'h03);
        // Count at max, then fire with auto-reload
        queue_tick();
        queue_tick();
        queue_tick();
        queue_write(irq_addr(IRQ_SEL_ACK), 8'h00);
        // Fire without auto-reload, then a tick while disabled
        queue_write(irq_addr(IRQ_SEL_CONTROL), 8'hFE);
        queue_tick();
        queue_tick();
        queue_tick();
        queue_write(16'hFFFF, 8'hFF);
        queue_tick();

        run_phase(0, 0);
        run_phase(54, 0);
        run_phase(0, 54);
        run_phase(38, 38);
        run_phase(0, 0);

        wait_all_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && bank_views_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
